// File: rtl/ifb_pkg.sv
// Shared types, codes and defaults for the indexed frame buffer blitter.
package ifb_pkg;

  // Default geometry and palette depth
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int PALETTE_SIZE_DEF  = 256;

  // Brightness full scale and its reset value
  localparam int         BRIGHT_MAX   = 63;
  localparam logic [5:0] BRIGHT_RESET = 6'd63;

  // Item function codes, carried on in_tuser
  typedef enum logic [2:0] {
    FUNC_PAL_LOAD     = 3'd0,
    FUNC_SPRITE_BEGIN = 3'd1,
    FUNC_SPRITE_PIXEL = 3'd2,
    FUNC_FILL         = 3'd3,
    FUNC_READ         = 3'd4
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPRITE_WIDTH  = 3'd0,
    REG_SPRITE_HEIGHT = 3'd1,
    REG_DEST_X        = 3'd2,
    REG_DEST_Y        = 3'd3,
    REG_TRANS_ENABLE  = 3'd4,
    REG_TRANS_KEY     = 3'd5,
    REG_BRIGHTNESS    = 3'd6
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_PIX_ADDR,
    ST_PIX_WR,
    ST_RD_FRAME,
    ST_RD_PAL,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_RESULT
  } state_t;

  // One palette color, red in the top byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Palette write request
  typedef struct packed {
    logic       we;
    logic [7:0] idx;
    rgb_t       rgb;
  } pal_wr_t;

endpackage

// File: rtl/ifb_frame_mem.sv
// Frame store: single-port-write, single-port-read RAM with registered read data.
module ifb_frame_mem import ifb_pkg::*; #(
  parameter int DEPTH = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
  parameter int AW    = $clog2(SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/ifb_palette.sv
// Palette RAM with per-entry valid bits so unwritten entries read as black.
module ifb_palette import ifb_pkg::*; #(
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pal_wr_t    wr,
  input  logic [7:0] rd_idx,
  output rgb_t       rd_rgb
);

  localparam int PW = $clog2(PALETTE_SIZE);

  rgb_t                    mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] valid_r;
  rgb_t                    rd_data_r;
  logic                    rd_valid_r;

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx[PW-1:0]] <= wr.rgb;
    end
    rd_data_r <= mem[rd_idx[PW-1:0]];
  end

  // Valid bits: cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.idx[PW-1:0]] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_idx[PW-1:0]];
    end
  end

  assign rd_rgb = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/ifb_scale.sv
// Brightness scaler: color * brightness / 63, two register stages.
module ifb_scale import ifb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  rgb_t       rgb_in,
  input  logic [5:0] bright,
  output logic       done,
  output rgb_t       rgb_out
);

  logic        v1_r;
  logic        done_r;
  logic [13:0] prod_r [3];
  rgb_t        rgb_out_r;

  // x / 63 for x < 2^14: estimate with x*1040 >> 16 (never high, at most
  // one low), then one compare and correct.
  function automatic logic [7:0] div63(input logic [13:0] x);
    logic [24:0] t;
    logic [8:0]  q;
    logic [14:0] r;
    t = ({11'b0, x} << 10) + ({11'b0, x} << 4);
    q = t[24:16];
    r = {1'b0, x} - 15'(({6'b0, q} << 6) - {6'b0, q});
    if (r >= 15'(BRIGHT_MAX)) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  // Stage 1: products; stage 2: quotients
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r[0] <= 14'(rgb_in.red)   * 14'(bright);
      prod_r[1] <= 14'(rgb_in.green) * 14'(bright);
      prod_r[2] <= 14'(rgb_in.blue)  * 14'(bright);
    end
    if (v1_r) begin
      rgb_out_r.red   <= div63(prod_r[0]);
      rgb_out_r.green <= div63(prod_r[1]);
      rgb_out_r.blue  <= div63(prod_r[2]);
    end
  end

  assign done    = done_r;
  assign rgb_out = rgb_out_r;

endmodule

// File: rtl/indexed_framebuffer_blitter.sv
// Indexed frame buffer with palette, color-key sprite blitter and scaled read-out.
//
// Input items arrive on in_tvalid/in_tready; in_tuser carries the function
// (palette load, begin sprite, sprite pixel, fill, read) and in_tdata the
// operands. Every accepted item yields exactly one result item on
// out_tvalid/out_tready: out_tdata holds the scaled color of a read (zero for
// other functions), out_tlast flags the sprite pixel that completed a sprite.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no item is in flight; the block itself does not enforce this.
// Steps per item: a sprite pixel computes the address (multiply), then
// writes the frame store; a read goes through frame store read, palette read
// and the two-stage scaler; a fill writes every frame store entry through the
// single frame store write port. Palette load, begin sprite and unused codes
// go straight to the result.
// After reset the frame store is cleared one entry a cycle; in_tready stays
// low meanwhile and configuration writes are taken as usual. The result
// sits in an output register; while the receiver stalls, the block holds its
// next result and takes no further item until the output register frees.
module indexed_framebuffer_blitter import ifb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // pal_index, red_in, green_in, blue_in, pixel, address[55:40]
  input  logic [2:0]  in_tuser,  // func
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // out_red, out_green, out_blue
  output logic        out_tlast, // sprite_done
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int FRAME_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  // Input fields
  func_t       in_func;
  logic [7:0]  in_pal_index;
  rgb_t        in_rgb;
  logic [7:0]  in_pixel;
  logic [15:0] in_address;

  assign in_func          = func_t'(in_tuser);
  assign in_pal_index     = in_tdata[7:0];
  assign in_rgb.red       = in_tdata[15:8];
  assign in_rgb.green     = in_tdata[23:16];
  assign in_rgb.blue      = in_tdata[31:24];
  assign in_pixel         = in_tdata[39:32];
  assign in_address       = in_tdata[55:40];

  // Configuration registers
  logic [10:0] sprite_width_r;
  logic [10:0] sprite_height_r;
  logic [11:0] dest_x_r;
  logic [11:0] dest_y_r;
  logic        trans_enable_r;
  logic [7:0]  trans_key_r;
  logic [5:0]  brightness_r;

  // Control and datapath registers
  state_t      state_r, state_nxt;
  logic [AW-1:0] mem_addr_r, mem_addr_nxt;
  logic [7:0]  pix_r, pix_nxt;
  logic [XW-1:0] sx_r, sx_nxt;
  logic [YW-1:0] sy_r, sy_nxt;
  logic        pix_hit_r, pix_hit_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic        black_r, black_nxt;
  logic [10:0] sprite_col_r, sprite_col_nxt;
  logic [10:0] sprite_row_r, sprite_row_nxt;
  rgb_t        res_rgb_r, res_rgb_nxt;
  logic        res_done_r, res_done_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  rgb_t        out_rgb_r, out_rgb_nxt;
  logic        out_tlast_r, out_tlast_nxt;

  // Memory and scaler connections
  logic        fr_we;
  logic [7:0]  fr_rdata;
  pal_wr_t     pal_wr;
  rgb_t        pal_rgb;
  logic        scl_start;
  rgb_t        scl_rgb_in;
  logic        scl_done;
  rgb_t        scl_rgb;

  // Handshake helpers
  logic in_acc;
  logic out_free;
  logic sweep_last;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign sweep_last = (mem_addr_r == AW'(FRAME_DEPTH - 1));

  // Sprite placement of the current pixel
  logic        spr_active;
  logic [12:0] sx, sy;
  logic        sx_on, sy_on, keyed;
  logic [11:0] col_inc, row_inc;

  always_comb begin
    spr_active = (sprite_width_r != 11'd0) && (sprite_height_r != 11'd0) &&
                 (sprite_row_r < sprite_height_r);
    sx      = {dest_x_r[11], dest_x_r} + {2'b00, sprite_col_r};
    sy      = {dest_y_r[11], dest_y_r} + {2'b00, sprite_row_r};
    sx_on   = !sx[12] && (sx < 13'(SCREEN_WIDTH));
    sy_on   = !sy[12] && (sy < 13'(SCREEN_HEIGHT));
    keyed   = trans_enable_r && (in_pixel == trans_key_r);
    col_inc = {1'b0, sprite_col_r} + 12'd1;
    row_inc = {1'b0, sprite_row_r} + 12'd1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_FILL:         state_nxt = ST_FILL;
            FUNC_SPRITE_PIXEL: state_nxt = ST_PIX_ADDR;
            FUNC_READ:         state_nxt = ST_RD_FRAME;
            default:           state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_FILL: begin
        if (sweep_last) state_nxt = ST_RESULT;
      end
      ST_PIX_ADDR:   state_nxt = ST_PIX_WR;
      ST_PIX_WR:     state_nxt = ST_RESULT;
      ST_RD_FRAME:   state_nxt = ST_RD_PAL;
      ST_RD_PAL:     state_nxt = ST_SCALE;
      ST_SCALE:      state_nxt = ST_SCALE_WAIT;
      ST_SCALE_WAIT: begin
        if (scl_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: handshake and memory strobes
  always_comb begin
    in_tready  = 1'b0;
    fr_we      = 1'b0;
    scl_start  = 1'b0;
    pal_wr.we  = 1'b0;
    pal_wr.idx = in_pal_index;
    pal_wr.rgb = in_rgb;
    scl_rgb_in = black_r ? '0 : pal_rgb;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        pal_wr.we = in_tvalid && (in_func == FUNC_PAL_LOAD) &&
                    ({1'b0, in_pal_index} < 9'(PALETTE_SIZE));
      end
      ST_CLEAR, ST_FILL: fr_we = 1'b1;
      ST_PIX_WR:         fr_we = pix_hit_r;
      ST_SCALE:          scl_start = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    mem_addr_nxt   = mem_addr_r;
    pix_nxt        = pix_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    pix_hit_nxt    = pix_hit_r;
    rd_ok_nxt      = rd_ok_r;
    black_nxt      = black_r;
    sprite_col_nxt = sprite_col_r;
    sprite_row_nxt = sprite_row_r;
    res_rgb_nxt    = res_rgb_r;
    res_done_nxt   = res_done_r;
    out_tvalid_nxt = out_tvalid_r;
    out_rgb_nxt    = out_rgb_r;
    out_tlast_nxt  = out_tlast_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pix_nxt      = in_pixel;
          res_rgb_nxt  = '0;
          res_done_nxt = 1'b0;
          case (in_func)
            FUNC_SPRITE_BEGIN: begin
              sprite_col_nxt = '0;
              sprite_row_nxt = '0;
            end
            FUNC_SPRITE_PIXEL: begin
              pix_hit_nxt = spr_active && !keyed && sx_on && sy_on;
              sx_nxt      = sx[XW-1:0];
              sy_nxt      = sy[YW-1:0];
              if (spr_active) begin
                if (col_inc >= {1'b0, sprite_width_r}) begin
                  sprite_col_nxt = '0;
                  sprite_row_nxt = row_inc[10:0];
                  res_done_nxt   = (row_inc >= {1'b0, sprite_height_r});
                end else begin
                  sprite_col_nxt = col_inc[10:0];
                end
              end
            end
            FUNC_FILL: mem_addr_nxt = '0;
            FUNC_READ: begin
              rd_ok_nxt    = ({16'b0, in_address} < 32'(FRAME_DEPTH));
              mem_addr_nxt = AW'(in_address);
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR, ST_FILL: begin
        mem_addr_nxt = sweep_last ? '0 : mem_addr_r + AW'(1);
      end
      ST_PIX_ADDR: begin
        mem_addr_nxt = AW'(sy_r) * AW'(SCREEN_WIDTH) + AW'(sx_r);
      end
      ST_RD_PAL: begin
        black_nxt = !rd_ok_r || ({1'b0, fr_rdata} >= 9'(PALETTE_SIZE));
      end
      ST_SCALE_WAIT: begin
        if (scl_done) res_rgb_nxt = scl_rgb;
      end
      default: ;
    endcase

    // Output register
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if ((state_r == ST_RESULT) && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_rgb_nxt    = res_rgb_r;
      out_tlast_nxt  = res_done_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      mem_addr_r   <= '0;
      pix_r        <= '0;
      sprite_col_r <= '0;
      sprite_row_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mem_addr_r   <= mem_addr_nxt;
      pix_r        <= pix_nxt;
      sprite_col_r <= sprite_col_nxt;
      sprite_row_r <= sprite_row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    pix_hit_r   <= pix_hit_nxt;
    rd_ok_r     <= rd_ok_nxt;
    black_r     <= black_nxt;
    res_rgb_r   <= res_rgb_nxt;
    res_done_r  <= res_done_nxt;
    out_rgb_r   <= out_rgb_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      trans_enable_r  <= 1'b0;
      trans_key_r     <= '0;
      brightness_r    <= BRIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[10:0];
        REG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[10:0];
        REG_DEST_X:        dest_x_r        <= cfg_wdata;
        REG_DEST_Y:        dest_y_r        <= cfg_wdata;
        REG_TRANS_ENABLE:  trans_enable_r  <= cfg_wdata[0];
        REG_TRANS_KEY:     trans_key_r     <= cfg_wdata[7:0];
        REG_BRIGHTNESS:    brightness_r    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Frame store
  ifb_frame_mem #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_frame (
    .clk     (clk),
    .wr_en   (fr_we),
    .wr_addr (mem_addr_r),
    .wr_data (pix_r),
    .rd_addr (mem_addr_r),
    .rd_data (fr_rdata)
  );

  // Palette
  ifb_palette #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd_idx (fr_rdata),
    .rd_rgb (pal_rgb)
  );

  // Brightness scaler
  ifb_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scl_start),
    .rgb_in  (scl_rgb_in),
    .bright  (brightness_r),
    .done    (scl_done),
    .rgb_out (scl_rgb)
  );

  // Ports
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_rgb_r.blue, out_rgb_r.green, out_rgb_r.red};
  assign out_tlast  = out_tlast_r;

  // No item is taken while the frame store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_FILL) |-> !in_tready)
    else $error("item accepted during frame store sweep");

  // Frame store writes only from a sweep or a sprite pixel write
  a_frame_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fr_we |-> (state_r == ST_CLEAR || state_r == ST_FILL || state_r == ST_PIX_WR))
    else $error("unexpected frame store write");

  // Scaler results only land while the controller waits for them
  a_scale_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    scl_done |-> (state_r == ST_SCALE_WAIT))
    else $error("scaler result outside wait state");

  // A sprite-done result never carries color
  a_last_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tlast_r) |-> (out_tdata == 24'd0))
    else $error("sprite done with nonzero color");

endmodule
